>>> src/sthl_pkg.sv
// ----------------------------------------------------------------------------
// sthl_pkg
// Shared types and constants of the sorted hash/type table lookup block:
// store geometry, item kinds, result codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sthl_pkg;

	localparam int MAX_TABLES  = 8;
	localparam int STORE_DEPTH = 1024;

	// Store address, entry count, table index and table count widths.
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CW   = AW + 1;
	localparam int TIW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int CNTW = $clog2(MAX_TABLES + 1);

	// Result field widths.
	localparam int OUT_TW = 3;
	localparam int OUT_EW = 10;

	typedef enum logic [1:0] {
		KIND_OPEN   = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TBL,
		S_PROBE,
		S_CMP,
		S_DOWN,
		S_DCMP,
		S_UP,
		S_UCMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_open;
		logic do_append;
		logic do_clear;
		logic t_clr;
		logic t_next;
		logic tbl_load;
		logic rd_mid;
		logic rd_down;
		logic rd_up;
		logic lo_up;
		logic hi_down;
		logic j_mid;
		logic j_set_off;
		logic j_up_init;
		logic j_inc;
		logic res_hit;
		logic res_miss;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  t_lt_tiu;
		logic  lo_lt_hi;
		logic  hash_eq;
		logic  hash_lt;
		logic  type_eq;
		logic  j_nz;
		logic  j_lt_n;
	} sts_t;

endpackage

>>> src/sthl_ctrl.sv
// ----------------------------------------------------------------------------
// sthl_ctrl
// Controller: sequences table updates and the per-table binary search with
// its downward and upward neighbor scans, and owns the result handshake.
// ----------------------------------------------------------------------------
module sthl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sthl_pkg::sts_t sts,
	output sthl_pkg::cmd_t cmd
);

	sthl_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sthl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == sthl_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sthl_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = sthl_pkg::S_EXEC;
				end
			end
			sthl_pkg::S_EXEC: begin
				unique case (sts.kind)
					sthl_pkg::KIND_OPEN: begin
						cmd.do_open = 1'b1;
						state_d     = sthl_pkg::S_DONE;
					end
					sthl_pkg::KIND_APPEND: begin
						cmd.do_append = 1'b1;
						state_d       = sthl_pkg::S_DONE;
					end
					sthl_pkg::KIND_CLEAR: begin
						cmd.do_clear = 1'b1;
						state_d      = sthl_pkg::S_DONE;
					end
					default: begin
						cmd.t_clr = 1'b1;
						state_d   = sthl_pkg::S_TBL;
					end
				endcase
			end
			sthl_pkg::S_TBL: begin
				if (sts.t_lt_tiu) begin
					cmd.tbl_load = 1'b1;
					state_d      = sthl_pkg::S_PROBE;
				end else begin
					cmd.res_miss = 1'b1;
					state_d      = sthl_pkg::S_DONE;
				end
			end
			sthl_pkg::S_PROBE: begin
				if (sts.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_d    = sthl_pkg::S_CMP;
				end else begin
					cmd.t_next = 1'b1;
					state_d    = sthl_pkg::S_TBL;
				end
			end
			sthl_pkg::S_CMP: begin
				if (sts.hash_eq && sts.type_eq) begin
					cmd.res_hit = 1'b1;
					state_d     = sthl_pkg::S_DONE;
				end else if (sts.hash_eq) begin
					cmd.j_mid = 1'b1;
					state_d   = sthl_pkg::S_DOWN;
				end else if (sts.hash_lt) begin
					cmd.lo_up = 1'b1;
					state_d   = sthl_pkg::S_PROBE;
				end else begin
					cmd.hi_down = 1'b1;
					state_d     = sthl_pkg::S_PROBE;
				end
			end
			sthl_pkg::S_DOWN: begin
				if (sts.j_nz) begin
					cmd.rd_down = 1'b1;
					state_d     = sthl_pkg::S_DCMP;
				end else begin
					cmd.j_up_init = 1'b1;
					state_d       = sthl_pkg::S_UP;
				end
			end
			sthl_pkg::S_DCMP: begin
				if (sts.hash_eq && sts.type_eq) begin
					cmd.res_hit = 1'b1;
					state_d     = sthl_pkg::S_DONE;
				end else if (sts.hash_eq) begin
					cmd.j_set_off = 1'b1;
					state_d       = sthl_pkg::S_DOWN;
				end else begin
					cmd.j_up_init = 1'b1;
					state_d       = sthl_pkg::S_UP;
				end
			end
			sthl_pkg::S_UP: begin
				if (sts.j_lt_n) begin
					cmd.rd_up = 1'b1;
					state_d   = sthl_pkg::S_UCMP;
				end else begin
					cmd.t_next = 1'b1;
					state_d    = sthl_pkg::S_TBL;
				end
			end
			sthl_pkg::S_UCMP: begin
				if (sts.hash_eq && sts.type_eq) begin
					cmd.res_hit = 1'b1;
					state_d     = sthl_pkg::S_DONE;
				end else if (sts.hash_eq) begin
					cmd.j_inc = 1'b1;
					state_d   = sthl_pkg::S_UP;
				end else begin
					cmd.t_next = 1'b1;
					state_d    = sthl_pkg::S_TBL;
				end
			end
			sthl_pkg::S_DONE: begin
				// The output register takes the result once its previous one is gone.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = sthl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sthl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> src/sthl_dp.sv
// ----------------------------------------------------------------------------
// sthl_dp
// Datapath: entry store memory, table descriptors, search registers, result
// and output registers. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module sthl_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    kind,
	input  logic [31:0]                   key_hash,
	input  logic [15:0]                   asset_type,
	input  sthl_pkg::cmd_t                cmd,
	output sthl_pkg::sts_t                sts,
	output logic [1:0]                    status,
	output logic [sthl_pkg::OUT_TW-1:0]   table_index,
	output logic [sthl_pkg::OUT_EW-1:0]   entry_index
);

	// Entry store, written by appends and read one entry per cycle.
	logic [31:0] mem_hash [sthl_pkg::STORE_DEPTH];
	logic [15:0] mem_type [sthl_pkg::STORE_DEPTH];

	sthl_pkg::kind_t kind_q;
	logic [31:0]     key_q;
	logic [15:0]     type_q;

	logic [sthl_pkg::CNTW-1:0] tiu_q;
	logic [sthl_pkg::CW-1:0]   eu_q;
	logic [sthl_pkg::AW-1:0]   start_q [sthl_pkg::MAX_TABLES];
	logic [sthl_pkg::CW-1:0]   size_q  [sthl_pkg::MAX_TABLES];

	logic [sthl_pkg::CNTW-1:0] t_q;
	logic [sthl_pkg::CW-1:0]   lo_q, hi_q, j_q, mid_q, rd_off_q;
	logic [31:0]               rd_hash_q;
	logic [15:0]               rd_type_q;

	logic [1:0]                  res_status_q;
	logic [sthl_pkg::OUT_TW-1:0] res_tix_q;
	logic [sthl_pkg::OUT_EW-1:0] res_eix_q;
	logic [1:0]                  out_status_q;
	logic [sthl_pkg::OUT_TW-1:0] out_tix_q;
	logic [sthl_pkg::OUT_EW-1:0] out_eix_q;

	logic [sthl_pkg::TIW-1:0] cur_t, newest;
	logic [sthl_pkg::AW-1:0]  base;
	logic [sthl_pkg::CW-1:0]  n, mid, rd_off, rd_sum;
	logic [sthl_pkg::AW-1:0]  rd_addr;
	logic                     rd_en, open_full, store_full, append_full;

	assign cur_t  = t_q[sthl_pkg::TIW-1:0];
	assign newest = sthl_pkg::TIW'(tiu_q - 1'b1);
	assign base   = start_q[cur_t];
	assign n      = size_q[cur_t];
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		if (cmd.rd_mid) begin
			rd_off = mid;
		end else if (cmd.rd_down) begin
			rd_off = j_q - 1'b1;
		end else begin
			rd_off = j_q;
		end
	end

	assign rd_sum  = {1'b0, base} + rd_off;
	assign rd_addr = rd_sum[sthl_pkg::AW-1:0];
	assign rd_en   = cmd.rd_mid | cmd.rd_down | cmd.rd_up;

	assign store_full  = (eu_q >= sthl_pkg::CW'(sthl_pkg::STORE_DEPTH));
	assign open_full   = (tiu_q >= sthl_pkg::CNTW'(sthl_pkg::MAX_TABLES)) || store_full;
	assign append_full = (tiu_q == '0) || store_full;

	always_ff @(posedge clk) begin
		if (cmd.do_append && !append_full) begin
			mem_hash[eu_q[sthl_pkg::AW-1:0]] <= key_q;
			mem_type[eu_q[sthl_pkg::AW-1:0]] <= type_q;
		end
		if (rd_en) begin
			rd_hash_q <= mem_hash[rd_addr];
			rd_type_q <= mem_type[rd_addr];
		end
	end

	// Table descriptors and fill counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiu_q <= '0;
			eu_q  <= '0;
			for (int i = 0; i < sthl_pkg::MAX_TABLES; i++) begin
				start_q[i] <= '0;
				size_q[i]  <= '0;
			end
		end else begin
			if (cmd.do_clear) begin
				tiu_q <= '0;
				eu_q  <= '0;
				for (int i = 0; i < sthl_pkg::MAX_TABLES; i++) begin
					start_q[i] <= '0;
					size_q[i]  <= '0;
				end
			end else if (cmd.do_open && !open_full) begin
				start_q[tiu_q[sthl_pkg::TIW-1:0]] <= eu_q[sthl_pkg::AW-1:0];
				size_q[tiu_q[sthl_pkg::TIW-1:0]]  <= '0;
				tiu_q <= tiu_q + 1'b1;
			end else if (cmd.do_append && !append_full) begin
				size_q[newest] <= size_q[newest] + 1'b1;
				eu_q           <= eu_q + 1'b1;
			end
		end
	end

	// Captured item, search registers and results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= sthl_pkg::kind_t'(kind);
			key_q  <= key_hash;
			type_q <= asset_type;
		end
		if (cmd.t_clr) begin
			t_q <= '0;
		end else if (cmd.t_next) begin
			t_q <= t_q + 1'b1;
		end
		if (cmd.tbl_load) begin
			lo_q <= '0;
			hi_q <= n;
		end else if (cmd.lo_up) begin
			lo_q <= mid_q + 1'b1;
		end else if (cmd.hi_down) begin
			hi_q <= mid_q;
		end
		if (cmd.rd_mid) begin
			mid_q <= mid;
		end
		if (rd_en) begin
			rd_off_q <= rd_off;
		end
		if (cmd.j_mid) begin
			j_q <= mid_q;
		end else if (cmd.j_set_off) begin
			j_q <= rd_off_q;
		end else if (cmd.j_up_init) begin
			j_q <= mid_q + 1'b1;
		end else if (cmd.j_inc) begin
			j_q <= j_q + 1'b1;
		end

		if (cmd.do_open) begin
			res_status_q <= open_full ? sthl_pkg::ST_FULL : sthl_pkg::ST_OK;
			res_tix_q    <= open_full ? '0 : sthl_pkg::OUT_TW'(tiu_q);
			res_eix_q    <= '0;
		end else if (cmd.do_append) begin
			res_status_q <= append_full ? sthl_pkg::ST_FULL : sthl_pkg::ST_OK;
			res_tix_q    <= append_full ? '0 : sthl_pkg::OUT_TW'(newest);
			res_eix_q    <= append_full ? '0 : sthl_pkg::OUT_EW'(size_q[newest]);
		end else if (cmd.do_clear || cmd.res_miss) begin
			res_status_q <= cmd.res_miss ? sthl_pkg::ST_MISS : sthl_pkg::ST_OK;
			res_tix_q    <= '0;
			res_eix_q    <= '0;
		end else if (cmd.res_hit) begin
			res_status_q <= sthl_pkg::ST_OK;
			res_tix_q    <= sthl_pkg::OUT_TW'(t_q);
			res_eix_q    <= sthl_pkg::OUT_EW'(rd_off_q);
		end

		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_tix_q    <= res_tix_q;
			out_eix_q    <= res_eix_q;
		end
	end

	assign sts.kind     = kind_q;
	assign sts.t_lt_tiu = (t_q < tiu_q);
	assign sts.lo_lt_hi = (lo_q < hi_q);
	assign sts.hash_eq  = (rd_hash_q == key_q);
	assign sts.hash_lt  = (rd_hash_q < key_q);
	assign sts.type_eq  = (rd_type_q == type_q);
	assign sts.j_nz     = (j_q != '0);
	assign sts.j_lt_n   = (j_q < n);

	assign status      = out_status_q;
	assign table_index = out_tix_q;
	assign entry_index = out_eix_q;

endmodule

>>> src/sorted_table_hash_type_lookup_core.sv
// Open, append and clear run from acceptance through an execute state to the done state.
// Lookup visits the open tables in order; each binary-search probe and each neighbor
// scanned takes a memory read, serialized by the single read port of the entry store.
// One item is in work at a time; the next is accepted while a result waits to be taken.
// Reset: arst_n clears all tables and counters; the entry store is not cleared.
// ----------------------------------------------------------------------------
// sorted_table_hash_type_lookup_core
// Up to eight sorted (hash, type) tables in one shared entry store, with open,
// append, clear and a binary-search lookup across all open tables.
// ----------------------------------------------------------------------------
module sorted_table_hash_type_lookup_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] key_hash,
	input  logic [15:0] asset_type,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  table_index,
	output logic [9:0]  entry_index
);

	sthl_pkg::cmd_t cmd;
	sthl_pkg::sts_t sts;

	sthl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sthl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.key_hash    (key_hash),
		.asset_type  (asset_type),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.table_index (table_index),
		.entry_index (entry_index)
	);

`ifndef ASSERT_OFF
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == sthl_pkg::ST_OK || status == sthl_pkg::ST_MISS ||
			status == sthl_pkg::ST_FULL))
		else $error("result carries an undefined status code");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sthl_pkg::ST_MISS) |-> (table_index == '0 && entry_index == '0))
		else $error("miss result carries nonzero indexes");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in work");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted hash/type table lookup core. A shadow copy
// of the tables predicts each result as its transaction is accepted. Results
// are checked in order against that prediction. Directed cases cover empty
// state, field extremes, neighbor scans and the table limit. Random phases
// build sorted tables, fill the store to its limit and mix in unsorted noise.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [1:0]                  status;
		logic [sthl_pkg::OUT_TW-1:0] table_index;
		logic [sthl_pkg::OUT_EW-1:0] entry_index;
	} lookup_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [31:0] key_hash;
	logic [15:0] asset_type;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [2:0]  table_index;
	logic [9:0]  entry_index;

	// Shadow copy of the block's tables.
	logic [31:0] shadow_hash [sthl_pkg::STORE_DEPTH];
	logic [15:0] shadow_type [sthl_pkg::STORE_DEPTH];
	int          tbl_start [sthl_pkg::MAX_TABLES];
	int          tbl_size [sthl_pkg::MAX_TABLES];
	int          tables_open;
	int          entries_used;

	lookup_result_t awaited_results[$];
	int             items_sent;
	int             mismatch_count;
	int             idle_cycles;
	bit             quiet;

	sorted_table_hash_type_lookup_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key_hash    (key_hash),
		.asset_type  (asset_type),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.table_index (table_index),
		.entry_index (entry_index)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Binary search of one table followed by the downward and upward scans.
	function automatic bit search_one(int t, logic [31:0] key, logic [15:0] ty,
	                                  output int pos);
		int base;
		int n;
		int lo;
		int hi;
		int mid;
		int j;
		bit done;
		bit hit;
		base = tbl_start[t];
		n    = tbl_size[t];
		lo   = 0;
		hi   = n;
		done = 1'b0;
		hit  = 1'b0;
		pos  = 0;
		while (lo < hi && !done) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_hash[base + mid] < key) begin
				lo = mid + 1;
			end else if (shadow_hash[base + mid] > key) begin
				hi = mid;
			end else begin
				done = 1'b1;
				if (shadow_type[base + mid] == ty) begin
					hit = 1'b1;
					pos = mid;
				end
				j = mid;
				while (!hit && j > 0 && shadow_hash[base + j - 1] == key) begin
					j--;
					if (shadow_type[base + j] == ty) begin
						hit = 1'b1;
						pos = j;
					end
				end
				j = mid + 1;
				while (!hit && j < n && shadow_hash[base + j] == key) begin
					if (shadow_type[base + j] == ty) begin
						hit = 1'b1;
						pos = j;
					end
					j++;
				end
			end
		end
		return hit;
	endfunction

	function automatic lookup_result_t step_tables(sthl_pkg::kind_t k, logic [31:0] key,
	                                               logic [15:0] ty);
		lookup_result_t r;
		int pos;
		int t;
		bit found;
		r.status      = sthl_pkg::ST_OK;
		r.table_index = '0;
		r.entry_index = '0;
		case (k)
			sthl_pkg::KIND_OPEN: begin
				if (tables_open >= sthl_pkg::MAX_TABLES ||
					entries_used >= sthl_pkg::STORE_DEPTH) begin
					r.status = sthl_pkg::ST_FULL;
				end else begin
					r.table_index          = tables_open[sthl_pkg::OUT_TW-1:0];
					tbl_start[tables_open] = entries_used;
					tbl_size[tables_open]  = 0;
					tables_open++;
				end
			end
			sthl_pkg::KIND_APPEND: begin
				if (tables_open == 0 || entries_used >= sthl_pkg::STORE_DEPTH) begin
					r.status = sthl_pkg::ST_FULL;
				end else begin
					t = tables_open - 1;
					shadow_hash[entries_used] = key;
					shadow_type[entries_used] = ty;
					r.table_index = t[sthl_pkg::OUT_TW-1:0];
					r.entry_index = tbl_size[t][sthl_pkg::OUT_EW-1:0];
					tbl_size[t]++;
					entries_used++;
				end
			end
			sthl_pkg::KIND_LOOKUP: begin
				r.status = sthl_pkg::ST_MISS;
				found    = 1'b0;
				for (t = 0; t < tables_open && !found; t++) begin
					if (search_one(t, key, ty, pos)) begin
						found         = 1'b1;
						r.status      = sthl_pkg::ST_OK;
						r.table_index = t[sthl_pkg::OUT_TW-1:0];
						r.entry_index = pos[sthl_pkg::OUT_EW-1:0];
					end
				end
			end
			default: begin
				for (t = 0; t < sthl_pkg::MAX_TABLES; t++) begin
					tbl_start[t] = 0;
					tbl_size[t]  = 0;
				end
				tables_open  = 0;
				entries_used = 0;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatch_count++;
	endtask

	// Sends one transaction and records its predicted result on acceptance.
	task automatic send_item(sthl_pkg::kind_t k, logic [31:0] key, logic [15:0] ty);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		key_hash   <= key;
		asset_type <= ty;
		do @(posedge clk); while (!in_ready);
		awaited_results.push_back(step_tables(k, key, ty));
		items_sent++;
	endtask

	// Appends n entries with nondecreasing hashes, with runs of equal hashes.
	task automatic append_sorted(int n, bit narrow_types);
		logic [32:0] h;
		logic [15:0] ty;
		int i;
		case ($urandom_range(0, 3))
			0: h = '0;
			1: h = {1'b0, $urandom};
			2: h = {1'b0, $urandom >> 12};
			default: h = 33'hFFFF_FFFF - 33'($urandom_range(0, 64));
		endcase
		for (i = 0; i < n; i++) begin
			ty = narrow_types ? 16'($urandom_range(0, 3)) : 16'($urandom);
			send_item(sthl_pkg::KIND_APPEND, h[31:0], ty);
			case ($urandom_range(0, 9))
				0, 1, 2: ;
				3, 4, 5, 6: h = h + 33'($urandom_range(1, 16));
				default: h = h + 33'($urandom >> $urandom_range(0, 31));
			endcase
			if (h > 33'hFFFF_FFFF) h = 33'hFFFF_FFFF;
		end
	endtask

	// Lookup keyed mostly from stored entries, with near misses on hash and type.
	task automatic lookup_mix();
		logic [31:0] key;
		logic [15:0] ty;
		int e;
		int r;
		r = $urandom_range(0, 99);
		if (entries_used == 0 || r < 15) begin
			key = $urandom;
			ty  = 16'($urandom);
		end else begin
			e   = $urandom_range(0, entries_used - 1);
			key = shadow_hash[e];
			ty  = shadow_type[e];
			if (r < 35) ty = 16'($urandom_range(0, 3));
			else if (r < 45) ty = 16'($urandom);
			else if (r < 55) key = key + 32'd1;
			else if (r < 62) key = key - 32'd1;
		end
		send_item(sthl_pkg::KIND_LOOKUP, key, ty);
	endtask

	task automatic test_empty_state();
		send_item(sthl_pkg::KIND_LOOKUP, 32'h0, 16'h0);
		send_item(sthl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_field_extremes();
		send_item(sthl_pkg::KIND_OPEN, 32'h0, 16'h0);
		send_item(sthl_pkg::KIND_APPEND, 32'h0, 16'h0);
		send_item(sthl_pkg::KIND_APPEND, 32'h0, 16'hFFFF);
		send_item(sthl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 16'h0);
		send_item(sthl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(sthl_pkg::KIND_LOOKUP, 32'h0, 16'hFFFF);
		send_item(sthl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0);
		send_item(sthl_pkg::KIND_LOOKUP, 32'h8000_0000, 16'h5A5A);
	endtask

	task automatic test_neighbor_scan();
		int i;
		send_item(sthl_pkg::KIND_OPEN, 32'h0, 16'h0);
		for (i = 1; i <= 4; i++) send_item(sthl_pkg::KIND_APPEND, 32'd5, i[15:0]);
		// The probe lands on type 3; type 1 needs the downward scan, type 4 the upward one.
		send_item(sthl_pkg::KIND_LOOKUP, 32'd5, 16'd1);
		send_item(sthl_pkg::KIND_LOOKUP, 32'd5, 16'd4);
		send_item(sthl_pkg::KIND_LOOKUP, 32'd5, 16'd7);
	endtask

	task automatic test_table_limit();
		int i;
		for (i = 2; i < sthl_pkg::MAX_TABLES; i++)
			send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_APPEND, 32'h1234_5678, 16'hABCD);
		send_item(sthl_pkg::KIND_CLEAR, 32'h0, 16'h0);
	endtask

	task automatic test_random_tables(int item_target);
		int ntab;
		int t;
		int n;
		while (items_sent < item_target) begin
			quiet = ($urandom_range(0, 3) == 0);
			send_item(sthl_pkg::KIND_CLEAR, $urandom, 16'($urandom));
			ntab = $urandom_range(1, sthl_pkg::MAX_TABLES);
			for (t = 0; t < ntab; t++) begin
				send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
				append_sorted(n, 1'($urandom_range(0, 1)));
				lookup_mix();
			end
			if ($urandom_range(0, 2) == 0)
				send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
			repeat ($urandom_range(10, 30)) lookup_mix();
		end
		quiet = 1'b0;
	endtask

	task automatic test_store_full();
		send_item(sthl_pkg::KIND_CLEAR, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		append_sorted(5, 1'b1);
		send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		append_sorted(sthl_pkg::STORE_DEPTH - entries_used, 1'($urandom_range(0, 1)));
		// The store is full here while table slots remain free.
		send_item(sthl_pkg::KIND_APPEND, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_APPEND, $urandom, 16'($urandom));
		send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
		repeat (30) lookup_mix();
		send_item(sthl_pkg::KIND_CLEAR, $urandom, 16'($urandom));
	endtask

	// Unsorted appends, stray opens and clears between lookups.
	task automatic test_noise(int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 12) send_item(sthl_pkg::KIND_OPEN, $urandom, 16'($urandom));
			else if (r < 55) send_item(sthl_pkg::KIND_APPEND, $urandom, 16'($urandom));
			else if (r < 97) lookup_mix();
			else send_item(sthl_pkg::KIND_CLEAR, $urandom, 16'($urandom));
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= sthl_pkg::KIND_OPEN;
		key_hash    <= '0;
		asset_type  <= '0;
		quiet        = 1'b0;
		items_sent   = 0;
		tables_open  = 0;
		entries_used = 0;
		for (int t = 0; t < sthl_pkg::MAX_TABLES; t++) begin
			tbl_start[t] = 0;
			tbl_size[t]  = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_state();
		test_field_extremes();
		test_neighbor_scan();
		test_table_limit();
		test_random_tables(700);
		test_store_full();
		test_noise(200);

		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Result side: random stalls, then each transaction is checked in order.
	initial begin
		lookup_result_t want;
		int stall;
		mismatch_count = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result status", int'(status), -1);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (table_index !== want.table_index)
					report_mismatch("table_index", int'(table_index), int'(want.table_index));
				if (entry_index !== want.entry_index)
					report_mismatch("entry_index", int'(entry_index), int'(want.entry_index));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
